### src/gf2m_pkg.sv
package gf2m_pkg;

	localparam int FIELD_BITS = 512;
	localparam int WORD_BITS = 64;
	localparam int NWORDS = FIELD_BITS / WORD_BITS;
	localparam int WIDX_BITS = $clog2(NWORDS);
	localparam int COL_BITS = WIDX_BITS + 1;
	localparam int MOD_DEG = 8;
	localparam int FOLD_BITS = WORD_BITS + MOD_DEG;

	// x^512 = x^8 + x^5 + x^2 + 1
	localparam logic [MOD_DEG:0] MOD_LOW = 9'h125;

	typedef struct packed {
		logic                valid;
		logic                last;
		logic                zero;
		logic [COL_BITS-1:0] col;
	} tag_t;

	function automatic logic [FOLD_BITS-1:0] mod_mul(input logic [WORD_BITS-1:0] h);
		logic [FOLD_BITS-1:0] r;
		r = '0;
		for (int t = 0; t <= MOD_DEG; t++) begin
			if (MOD_LOW[t]) begin
				r = r ^ ({{MOD_DEG{1'b0}}, h} << t);
			end
		end
		return r;
	endfunction

endpackage

### src/gf2_512_multiplier.sv
// channel   | ports                          | handshake
// ----------+--------------------------------+--------------------------------
// operand   | lhs_word, rhs_word             | start high while busy low
// product   | product_word, last_word        | strobe high with each word
//
// seven of every eight operand transactions are accepted without raising busy.
// the eighth sets busy: 64 word products, one per cycle, and a
// flush slot through the shared 64x64 carry-less unit, a reduction tail,
// then eight product words on consecutive cycles, busy falling with the last one.
// operands and the partial result live in 8x64 synchronous memories.
// after reset the block accepts at once; products cannot be stalled.
module gf2_512_multiplier (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [gf2m_pkg::WORD_BITS-1:0]  lhs_word,
	input  logic [gf2m_pkg::WORD_BITS-1:0]  rhs_word,
	output logic                            strobe,
	output logic [gf2m_pkg::WORD_BITS-1:0]  product_word,
	output logic                            last_word
);
	import gf2m_pkg::*;

	typedef enum logic [2:0] {
		S_COLLECT,
		S_MUL,
		S_DRAIN,
		S_OUT,
		S_TAIL
	} state_t;

	localparam logic [COL_BITS-1:0] COL_FLUSH = COL_BITS'(2 * NWORDS - 1);
	localparam logic [WIDX_BITS-1:0] IDX_MAX = WIDX_BITS'(NWORDS - 1);

	state_t                 state_q;
	logic                   busy_q;
	logic [WIDX_BITS-1:0]   cnt_q;
	logic [COL_BITS-1:0]    seq_s_q;
	logic [WIDX_BITS-1:0]   seq_i_q;
	logic [WIDX_BITS-1:0]   out_idx_q;

	logic [WORD_BITS-1:0]   opa_mem [NWORDS];
	logic [WORD_BITS-1:0]   opb_mem [NWORDS];
	logic [WORD_BITS-1:0]   res_mem [NWORDS];

	logic [WORD_BITS-1:0]   rd_a_s1;
	logic [WORD_BITS-1:0]   rd_b_s1;
	tag_t                   tag_s1;
	logic [2*WORD_BITS-1:0] prod_s2;
	tag_t                   tag_s2;

	logic [2*WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0]   col_s3;
	logic [COL_BITS-1:0]    col_k_s3;
	logic                   col_v_s3;
	logic [WORD_BITS-1:0]   hw_s4;
	logic [WIDX_BITS-1:0]   w_s4;
	logic                   v_s4;
	logic [MOD_DEG-1:0]     carry8_q;
	logic [WORD_BITS-1:0]   res_rd_q;

	logic                   out_v_s1;
	logic [WIDX_BITS-1:0]   out_idx_s1;
	logic                   strobe_q;
	logic                   last_word_q;
	logic [WORD_BITS-1:0]   product_word_q;

	logic                   accept;
	logic                   job_go;
	logic [WIDX_BITS-1:0]   diag_hi;
	logic [WIDX_BITS-1:0]   seq_j;
	logic [COL_BITS-1:0]    nxt_s;
	logic [WIDX_BITS-1:0]   i_start;
	logic                   diag_end;
	tag_t                   issue;
	logic [2*WORD_BITS-1:0] sum;
	logic [FOLD_BITS-1:0]   fold;
	logic [FOLD_BITS-1:0]   fix_full;
	logic [WORD_BITS-1:0]   fix_word;
	logic [WIDX_BITS-1:0]   res_raddr;
	logic                   pipe_empty;

	assign accept = start && !busy_q;
	assign job_go = accept && (cnt_q == IDX_MAX);

	// diagonal walk: word pairs with i + j == s
	assign diag_hi = seq_s_q[COL_BITS-1] ? IDX_MAX : seq_s_q[WIDX_BITS-1:0];
	assign seq_j = WIDX_BITS'(seq_s_q - COL_BITS'(seq_i_q));
	assign nxt_s = seq_s_q + COL_BITS'(1);
	assign i_start = nxt_s[COL_BITS-1] ? WIDX_BITS'(nxt_s - COL_BITS'(NWORDS - 1)) : '0;
	assign diag_end = (seq_i_q == diag_hi);

	always_comb begin
		issue.valid = (state_q == S_MUL);
		issue.zero = (seq_s_q == COL_FLUSH);
		issue.last = (seq_s_q == COL_FLUSH) || diag_end;
		issue.col = seq_s_q;
	end

	assign sum = acc_q ^ prod_s2;
	assign fold = mod_mul(hw_s4);
	assign fix_full = mod_mul(WORD_BITS'(carry8_q));
	assign fix_word = fix_full[WORD_BITS-1:0];
	assign res_raddr = (state_q == S_OUT) ? out_idx_q : col_k_s3[WIDX_BITS-1:0];
	assign pipe_empty = !tag_s1.valid && !tag_s2.valid && !col_v_s3 && !v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLLECT;
			busy_q <= 1'b0;
			cnt_q <= '0;
			seq_s_q <= '0;
			seq_i_q <= '0;
			out_idx_q <= '0;
			tag_s1 <= '0;
			col_v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_v_s1 <= 1'b0;
			out_idx_s1 <= '0;
			strobe_q <= 1'b0;
			last_word_q <= 1'b0;
		end else begin
			tag_s1 <= issue;
			col_v_s3 <= tag_s2.valid && tag_s2.last;
			v_s4 <= col_v_s3 && col_k_s3[COL_BITS-1];
			strobe_q <= out_v_s1;
			last_word_q <= out_v_s1 && (out_idx_s1 == IDX_MAX);
			out_idx_s1 <= out_idx_q;
			out_v_s1 <= (state_q == S_OUT);
			unique case (state_q)
				S_COLLECT: begin
					if (accept) begin
						cnt_q <= cnt_q + WIDX_BITS'(1);
					end
					if (job_go) begin
						state_q <= S_MUL;
						busy_q <= 1'b1;
						seq_s_q <= '0;
						seq_i_q <= '0;
					end
				end
				S_MUL: begin
					if (seq_s_q == COL_FLUSH) begin
						state_q <= S_DRAIN;
					end else if (diag_end) begin
						seq_s_q <= nxt_s;
						seq_i_q <= i_start;
					end else begin
						seq_i_q <= seq_i_q + WIDX_BITS'(1);
					end
				end
				S_DRAIN: begin
					if (pipe_empty) begin
						state_q <= S_OUT;
						out_idx_q <= '0;
					end
				end
				S_OUT: begin
					out_idx_q <= out_idx_q + WIDX_BITS'(1);
					if (out_idx_q == IDX_MAX) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					state_q <= S_COLLECT;
					busy_q <= 1'b0;
				end
				default: begin
					state_q <= S_COLLECT;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	// operand memories
	always_ff @(posedge clk) begin
		if (accept) begin
			opa_mem[cnt_q] <= lhs_word;
			opb_mem[cnt_q] <= rhs_word;
		end
		rd_a_s1 <= opa_mem[seq_i_q];
		rd_b_s1 <= opb_mem[seq_j];
	end

	gf2m_clmul u_clmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.a       (rd_a_s1),
		.b       (rd_b_s1),
		.tag_in  (tag_s1),
		.prod    (prod_s2),
		.tag_out (tag_s2)
	);

	// column accumulator and high-half fold
	always_ff @(posedge clk) begin
		if (job_go) begin
			acc_q <= '0;
			carry8_q <= '0;
		end else begin
			if (tag_s2.valid) begin
				if (tag_s2.last) begin
					acc_q <= {{WORD_BITS{1'b0}}, sum[2*WORD_BITS-1:WORD_BITS]};
				end else begin
					acc_q <= sum;
				end
			end
			if (v_s4) begin
				carry8_q <= fold[FOLD_BITS-1:WORD_BITS];
			end
		end
		if (tag_s2.valid) begin
			col_s3 <= sum[WORD_BITS-1:0];
			col_k_s3 <= tag_s2.col;
		end
		hw_s4 <= col_s3;
		w_s4 <= col_k_s3[WIDX_BITS-1:0];
		product_word_q <= res_rd_q ^ ((out_idx_s1 == '0) ? fix_word : '0);
	end

	// result memory: low columns written, high columns folded in place
	always_ff @(posedge clk) begin
		if (col_v_s3 && !col_k_s3[COL_BITS-1]) begin
			res_mem[col_k_s3[WIDX_BITS-1:0]] <= col_s3;
		end else if (v_s4) begin
			res_mem[w_s4] <= res_rd_q ^ fold[WORD_BITS-1:0] ^ WORD_BITS'(carry8_q);
		end
		res_rd_q <= res_mem[res_raddr];
	end

	assign busy = busy_q;
	assign strobe = strobe_q;
	assign last_word = last_word_q;
	assign product_word = product_word_q;

endmodule

### src/gf2m_clmul.sv
module gf2m_clmul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [gf2m_pkg::WORD_BITS-1:0]       a,
	input  logic [gf2m_pkg::WORD_BITS-1:0]       b,
	input  gf2m_pkg::tag_t                       tag_in,
	output logic [2*gf2m_pkg::WORD_BITS-1:0]     prod,
	output gf2m_pkg::tag_t                       tag_out
);
	import gf2m_pkg::*;

	logic [2*WORD_BITS-1:0] pp;

	always_comb begin
		pp = '0;
		for (int n = 0; n < WORD_BITS; n++) begin
			if (b[n]) begin
				pp = pp ^ ({{WORD_BITS{1'b0}}, a} << n);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else begin
			tag_out <= tag_in;
		end
	end

	// flush slot carries a zero product
	always_ff @(posedge clk) begin
		prod <= tag_in.zero ? '0 : pp;
	end

endmodule

### src/gf2m_checker.sv
module gf2m_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic last_word
);

	// busy only rises after an accepted transaction
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start transaction");

	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_word |-> strobe)
		else $error("last_word without strobe");

	a_words_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_word |-> busy)
		else $error("product word outside busy window");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_word |=> strobe)
		else $error("product burst broken");

	a_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_word |=> !strobe)
		else $error("product word after last");

endmodule

bind gf2_512_multiplier gf2m_checker u_gf2m_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.last_word (last_word)
);

### dv/testbench.sv
`timescale 1ns / 1ps

typedef struct packed {
	logic [gf2m_pkg::WORD_BITS-1:0] word;
	logic                           last;
} product_word_t;

// x^512 + x^8 + x^5 + x^2 + 1
localparam logic [1023:0] FIELD_POLY = (1024'b1 << 512) | 1024'h125;

class product_scoreboard;
	logic [gf2m_pkg::WORD_BITS-1:0] lhs_words[gf2m_pkg::NWORDS];
	logic [gf2m_pkg::WORD_BITS-1:0] rhs_words[gf2m_pkg::NWORDS];
	int unsigned                    word_pos;
	product_word_t                  expected_words[$];
	int unsigned                    errors;
	int unsigned                    words_checked;
	int unsigned                    transactions;
	int unsigned                    products;

	function new();
		word_pos = 0;
		errors = 0;
		words_checked = 0;
		transactions = 0;
		products = 0;
	endfunction

	function logic [511:0] field_multiply(input logic [511:0] a, input logic [511:0] b);
		logic [1023:0] acc;
		acc = '0;
		for (int i = 0; i < 512; i++) begin
			if (b[i]) begin
				acc = acc ^ ({512'b0, a} << i);
			end
		end
		for (int k = 1023; k >= 512; k--) begin
			if (acc[k]) begin
				acc = acc ^ (FIELD_POLY << (k - 512));
			end
		end
		return acc[511:0];
	endfunction

	function void note_operand(input logic [63:0] lhs, input logic [63:0] rhs);
		logic [511:0] a;
		logic [511:0] b;
		logic [511:0] p;
		product_word_t pw;
		lhs_words[word_pos] = lhs;
		rhs_words[word_pos] = rhs;
		transactions++;
		if (word_pos != gf2m_pkg::NWORDS - 1) begin
			word_pos++;
			return;
		end
		word_pos = 0;
		for (int i = 0; i < gf2m_pkg::NWORDS; i++) begin
			a[64*i +: 64] = lhs_words[i];
			b[64*i +: 64] = rhs_words[i];
		end
		p = field_multiply(a, b);
		products++;
		for (int i = 0; i < gf2m_pkg::NWORDS; i++) begin
			pw.word = p[64*i +: 64];
			pw.last = (i == gf2m_pkg::NWORDS - 1);
			expected_words.push_back(pw);
		end
	endfunction

	function void check_product(input logic [63:0] word, input logic last);
		product_word_t pw;
		if (expected_words.size() == 0) begin
			$display("%0t: unexpected product word %h last %b", $time, word, last);
			errors++;
			return;
		end
		pw = expected_words.pop_front();
		words_checked++;
		if (word !== pw.word) begin
			$display("%0t: product_word mismatch: expected %h actual %h", $time, pw.word, word);
			errors++;
		end
		if (last !== pw.last) begin
			$display("%0t: last_word mismatch: expected %b actual %b", $time, pw.last, last);
			errors++;
		end
	endfunction

	function int unsigned pending();
		return expected_words.size();
	endfunction
endclass

module testbench;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [63:0] lhs_word = '0;
	logic [63:0] rhs_word = '0;
	logic        busy;
	logic        strobe;
	logic [63:0] product_word;
	logic        last_word;

	product_scoreboard sb = new();
	int unsigned       cycles = 0;

	gf2_512_multiplier u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.lhs_word(lhs_word),
		.rhs_word(rhs_word),
		.strobe(strobe),
		.product_word(product_word),
		.last_word(last_word)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			sb.check_product(product_word, last_word);
		end
	end

	function automatic logic [63:0] random_word();
		logic [63:0] w;
		case ($urandom_range(0, 9))
			0: w = '0;
			1: w = '1;
			2: w = 64'b1 << $urandom_range(0, 63);
			default: w = {$urandom, $urandom};
		endcase
		return w;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_operand(input logic [63:0] lhs, input logic [63:0] rhs,
			input int unsigned idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		lhs_word <= lhs;
		rhs_word <= rhs;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_operand(lhs, rhs);
		@(negedge clk);
	endtask

	task automatic drain_products();
		start <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
	endtask

	initial begin
		int unsigned idle_pct[4];
		bit          narrow;
		logic [63:0] lhs;
		logic [63:0] rhs;
		idle_pct = '{0, 52, 0, 32};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// all ones times all ones
		for (int w = 0; w < 8; w++) send_operand('1, '1, 0);
		// x^511 squared, top bits only, folds back through the reduction
		for (int w = 0; w < 8; w++) begin
			lhs = (w == 7) ? 64'h8000_0000_0000_0000 : 64'h0;
			send_operand(lhs, lhs, 0);
		end
		// narrow multiply: rhs above word zero is zero
		for (int w = 0; w < 8; w++) send_operand({$urandom, $urandom},
				(w == 0) ? {$urandom, $urandom} : 64'h0, 0);

		for (int ph = 0; ph < 4; ph++) begin
			for (int g = 0; g < 15; g++) begin
				narrow = ($urandom_range(0, 5) == 0);
				for (int w = 0; w < 8; w++) begin
					lhs = random_word();
					rhs = (narrow && w != 0) ? 64'h0 : random_word();
					send_operand(lhs, rhs, idle_pct[ph]);
				end
			end
			drain_products();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d operand transactions, %0d products, %0d product words checked",
			sb.transactions, sb.products, sb.words_checked);
		$display("operands: extremes, single bits, narrow multiplies, random; idle 0/52/32 pct");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### sim.f
src/gf2m_pkg.sv
src/gf2m_clmul.sv
src/gf2_512_multiplier.sv
src/gf2m_checker.sv
dv/testbench.sv
